FILE: hdl/spht_pkg.sv
// Shared types and constants for the sample profiler hot address table.
// Used by the interfaces, the divider and the top level. No dependencies.
package spht_pkg;

    localparam int SESSIONS_DEF = 4;
    localparam int SAMPLES_DEF  = 1024;
    localparam int HOT_DEF      = 1024;

    localparam int CNT_W    = 11;    // fill, hit and table counts
    localparam int ADDR_W   = 64;
    localparam int PCT_W    = 15;
    localparam int DIVD_W   = 25;    // hits * 25600 fits in 25 bits
    localparam int PCT_SCALE = 25600; // 100.0 in Q8

    typedef enum logic [2:0] {
        REQ_START   = 3'd0,
        REQ_STOP    = 3'd1,
        REQ_PAUSE   = 3'd2,
        REQ_RESUME  = 3'd3,
        REQ_RECORD  = 3'd4,
        REQ_ANALYZE = 3'd5,
        REQ_READ    = 3'd6,
        REQ_TOTALS  = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        MODE_NONE      = 2'd0,
        MODE_RECORDING = 2'd1,
        MODE_PAUSED    = 2'd2,
        MODE_STOPPED   = 2'd3
    } mode_t;

    typedef struct packed {
        logic              ok;
        logic [3:0]        new_session;
        logic [CNT_W-1:0]  count_out;
        logic [ADDR_W-1:0] address_out;
        logic [PCT_W-1:0]  percent_q8;
        logic [3:0]        session_count;
        logic [31:0]       total_collected;
        logic [31:0]       total_dropped;
    } res_t;

endpackage

FILE: hdl/spht_req_if.sv
// Request channel interface: valid/ready plus request payload.
// Depends on spht_pkg.
interface spht_req_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 req_type;
    logic [7:0]                 session;
    logic [spht_pkg::ADDR_W-1:0] code_address;
    logic [9:0]                 entry_index;

    modport source (output valid, req_type, session, code_address, entry_index,
                    input ready);
    modport sink (input valid, req_type, session, code_address, entry_index,
                  output ready);
endinterface

FILE: hdl/spht_res_if.sv
// Result channel interface: valid/ready plus result payload.
// Depends on spht_pkg.
interface spht_res_if;
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic [3:0]                  new_session;
    logic [spht_pkg::CNT_W-1:0]  count_out;
    logic [spht_pkg::ADDR_W-1:0] address_out;
    logic [spht_pkg::PCT_W-1:0]  percent_q8;
    logic [3:0]                  session_count;
    logic [31:0]                 total_collected;
    logic [31:0]                 total_dropped;

    modport source (output valid, ok, new_session, count_out, address_out, percent_q8,
                    session_count, total_collected, total_dropped, input ready);
    modport sink (input valid, ok, new_session, count_out, address_out, percent_q8,
                  session_count, total_collected, total_dropped, output ready);
endinterface

FILE: hdl/spht_div.sv
// Restoring bit-serial divider for the Q8 percentage, one quotient bit a cycle.
// Depends on spht_pkg.
module spht_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [spht_pkg::DIVD_W-1:0]   dividend,
    input  logic [spht_pkg::CNT_W-1:0]    divisor,
    output logic                          done,
    output logic [spht_pkg::DIVD_W-1:0]   quotient
);
    localparam int CW = $clog2(spht_pkg::DIVD_W + 1);

    logic [spht_pkg::CNT_W-1:0]  rem_reg, rem_next;
    logic [spht_pkg::DIVD_W-1:0] quo_reg, quo_next;
    logic [spht_pkg::CNT_W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [spht_pkg::CNT_W:0]    trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[spht_pkg::DIVD_W-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(spht_pkg::DIVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = spht_pkg::CNT_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[spht_pkg::DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[spht_pkg::CNT_W-1:0];
                quo_next = {quo_reg[spht_pkg::DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("divider done without a run");
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> divisor != '0) else $error("divider started with zero divisor");
`endif

endmodule

FILE: hdl/sample_profiler_hot_address_table.sv
// Top level of the sampling profiler: session slots, sample and hot tables,
// analysis sequencer. Depends on spht_pkg, spht_req_if, spht_res_if, spht_div.
//
// Usage: requests enter on the req channel (valid/ready), one result per
// request leaves on the res channel (valid/ready). A transaction happens on
// a rising edge with valid and ready high.
// Ready is high only while the sequencer is idle.
// Start, stop, pause, resume, record and totals pass through the execute
// state and the result register before the result is presented; the block
// takes the next request once it is back in idle. Read entry adds a table
// read and, when the slot's base is nonzero, a percentage from the
// bit-serial divider, one quotient bit a cycle.
// Analyze walks the slot's samples through one shared address comparator
// fed from the hot table's single read port: for each sample it reads the
// table entries in turn until one matches (hit count plus one) or the end
// is reached (append with one hit), stopping when the table is full.
// Reset clears all slots, fill counts and totals at once; no clearing pass.
// A finished result sits in the output register; when the receiver stalls,
// the next request is still accepted and executed, and the sequencer holds
// its result until the output register frees.
module sample_profiler_hot_address_table
#(
    parameter int SESSIONS = spht_pkg::SESSIONS_DEF,
    parameter int SAMPLES  = spht_pkg::SAMPLES_DEF,
    parameter int HOT      = spht_pkg::HOT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    spht_req_if.sink    req,
    spht_res_if.source  res
);
    localparam int SLOT_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int SA_W   = (SESSIONS * SAMPLES > 1) ? $clog2(SESSIONS * SAMPLES) : 1;
    localparam int HA_W   = (SESSIONS * HOT > 1) ? $clog2(SESSIONS * HOT) : 1;
    localparam int CW     = spht_pkg::CNT_W;
    localparam int AW     = spht_pkg::ADDR_W;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_EXEC    = 8'b0000_0010,
        ST_AN_SAMP = 8'b0000_0100,
        ST_AN_SLAT = 8'b0000_1000,
        ST_AN_CMP  = 8'b0001_0000,
        ST_RD_WAIT = 8'b0010_0000,
        ST_DIV     = 8'b0100_0000,
        ST_DONE    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    spht_pkg::req_t  rtype_reg;
    logic [7:0]      sess_reg;
    logic [AW-1:0]   saddr_reg;
    logic [9:0]      idx_reg;

    logic            used_reg [SESSIONS];
    logic            used_next [SESSIONS];
    spht_pkg::mode_t mode_reg [SESSIONS];
    spht_pkg::mode_t mode_next [SESSIONS];
    logic [CW-1:0]   fill_reg [SESSIONS];
    logic [CW-1:0]   fill_next [SESSIONS];
    logic [CW-1:0]   hfill_reg [SESSIONS];
    logic [CW-1:0]   hfill_next [SESSIONS];
    logic [CW-1:0]   base_reg [SESSIONS];
    logic [CW-1:0]   base_next [SESSIONS];

    logic [3:0]      active_reg, active_next;
    logic [31:0]     coll_reg, coll_next;
    logic [31:0]     drop_reg, drop_next;

    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   j_reg, j_next;

    spht_pkg::res_t  res_reg, res_next;
    spht_pkg::res_t  out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    logic [AW-1:0]   samp_mem [SESSIONS * SAMPLES];
    logic [AW-1:0]   haddr_mem [SESSIONS * HOT];
    logic [CW-1:0]   hhits_mem [SESSIONS * HOT];
    logic [AW-1:0]   samp_rd_reg;
    logic [AW-1:0]   haddr_rd_reg;
    logic [CW-1:0]   hhits_rd_reg;

    logic            samp_we, samp_re;
    logic [SA_W-1:0] samp_wa, samp_ra;
    logic            ha_we, hh_we, h_re;
    logic [HA_W-1:0] h_wa, h_ra;
    logic [CW-1:0]   hh_wd;

    logic [SLOT_W-1:0] slot;
    logic              sess_ok;
    logic [SLOT_W-1:0] free_slot;
    logic              free_found;

    logic                        div_start;
    logic [spht_pkg::DIVD_W-1:0] div_dividend;
    logic                        div_done;
    logic [spht_pkg::DIVD_W-1:0] div_quotient;

    spht_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (base_reg[slot]),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign slot    = SLOT_W'(sess_reg - 8'd1);
    assign sess_ok = (sess_reg != 8'd0) && (int'(sess_reg) <= SESSIONS) && used_reg[slot];

    always_comb
    begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int k = SESSIONS - 1; k >= 0; k--)
        begin
            if (!used_reg[k])
            begin
                free_slot  = SLOT_W'(k);
                free_found = 1'b1;
            end
        end
    end

    assign div_dividend = spht_pkg::DIVD_W'(hhits_rd_reg) *
                          spht_pkg::DIVD_W'(spht_pkg::PCT_SCALE);

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        mode_next      = mode_reg;
        fill_next      = fill_reg;
        hfill_next     = hfill_reg;
        base_next      = base_reg;
        active_next    = active_reg;
        coll_next      = coll_reg;
        drop_next      = drop_reg;
        i_next         = i_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        samp_we        = 1'b0;
        samp_re        = 1'b0;
        samp_wa        = SA_W'(int'(slot) * SAMPLES + int'(fill_reg[slot]));
        samp_ra        = SA_W'(int'(slot) * SAMPLES + int'(i_reg));
        ha_we          = 1'b0;
        hh_we          = 1'b0;
        h_re           = 1'b0;
        h_wa           = SA_W > 0 ? HA_W'(int'(slot) * HOT + int'(n_reg)) : '0;
        h_ra           = HA_W'(int'(slot) * HOT + int'(j_reg));
        hh_wd          = CW'(1);
        div_start      = 1'b0;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_next   = '0;
                state_next = ST_DONE;
                unique case (rtype_reg) inside
                    spht_pkg::REQ_START:
                    begin
                        if (int'(active_reg) < SESSIONS && free_found)
                        begin
                            used_next[free_slot]  = 1'b1;
                            mode_next[free_slot]  = spht_pkg::MODE_RECORDING;
                            fill_next[free_slot]  = '0;
                            hfill_next[free_slot] = '0;
                            base_next[free_slot]  = '0;
                            active_next           = active_reg + 4'd1;
                            res_next.ok           = 1'b1;
                            res_next.new_session  = 4'(free_slot) + 4'd1;
                        end
                    end
                    spht_pkg::REQ_STOP:
                    begin
                        if (sess_ok)
                        begin
                            mode_next[slot] = spht_pkg::MODE_STOPPED;
                            if (active_reg != 4'd0)
                            begin
                                active_next = active_reg - 4'd1;
                            end
                            res_next.ok = 1'b1;
                        end
                    end
                    spht_pkg::REQ_PAUSE, spht_pkg::REQ_RESUME:
                    begin
                        if (sess_ok)
                        begin
                            mode_next[slot] = (rtype_reg == spht_pkg::REQ_PAUSE) ?
                                              spht_pkg::MODE_PAUSED :
                                              spht_pkg::MODE_RECORDING;
                            res_next.ok = 1'b1;
                        end
                    end
                    spht_pkg::REQ_RECORD:
                    begin
                        if (sess_ok && mode_reg[slot] == spht_pkg::MODE_RECORDING)
                        begin
                            if (int'(fill_reg[slot]) >= SAMPLES)
                            begin
                                drop_next = drop_reg + 32'd1;
                            end
                            else
                            begin
                                samp_we         = 1'b1;
                                fill_next[slot] = fill_reg[slot] + CW'(1);
                                coll_next       = coll_reg + 32'd1;
                                res_next.ok     = 1'b1;
                            end
                        end
                    end
                    spht_pkg::REQ_ANALYZE:
                    begin
                        if (sess_ok)
                        begin
                            i_next     = '0;
                            n_next     = '0;
                            state_next = ST_AN_SAMP;
                        end
                    end
                    spht_pkg::REQ_READ:
                    begin
                        if (sess_ok && {1'b0, idx_reg} < hfill_reg[slot])
                        begin
                            h_ra       = HA_W'(int'(slot) * HOT + int'(idx_reg));
                            h_re       = 1'b1;
                            state_next = ST_RD_WAIT;
                        end
                    end
                    default:
                    begin
                        res_next.ok              = 1'b1;
                        res_next.session_count   = active_reg;
                        res_next.total_collected = coll_reg;
                        res_next.total_dropped   = drop_reg;
                    end
                endcase
            end
            ST_AN_SAMP:
            begin
                if (i_reg >= fill_reg[slot] || int'(n_reg) >= HOT)
                begin
                    hfill_next[slot]   = n_reg;
                    base_next[slot]    = fill_reg[slot];
                    res_next.ok        = 1'b1;
                    res_next.count_out = n_reg;
                    state_next         = ST_DONE;
                end
                else
                begin
                    samp_re    = 1'b1;
                    j_next     = '0;
                    state_next = ST_AN_SLAT;
                end
            end
            ST_AN_SLAT:
            begin
                if (j_reg == n_reg)
                begin
                    // no match in the table: append with one hit
                    ha_we      = 1'b1;
                    hh_we      = 1'b1;
                    n_next     = n_reg + CW'(1);
                    i_next     = i_reg + CW'(1);
                    state_next = ST_AN_SAMP;
                end
                else
                begin
                    h_re       = 1'b1;
                    state_next = ST_AN_CMP;
                end
            end
            ST_AN_CMP:
            begin
                if (haddr_rd_reg == samp_rd_reg)
                begin
                    hh_we      = 1'b1;
                    h_wa       = HA_W'(int'(slot) * HOT + int'(j_reg));
                    hh_wd      = hhits_rd_reg + CW'(1);
                    i_next     = i_reg + CW'(1);
                    state_next = ST_AN_SAMP;
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = ST_AN_SLAT;
                end
            end
            ST_RD_WAIT:
            begin
                res_next.ok          = 1'b1;
                res_next.count_out   = hhits_rd_reg;
                res_next.address_out = haddr_rd_reg;
                if (base_reg[slot] != '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next.percent_q8 = div_quotient[spht_pkg::PCT_W-1:0];
                    state_next          = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register frees
                if (!out_valid_reg || res.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            coll_reg      <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < SESSIONS; k++)
            begin
                used_reg[k]  <= 1'b0;
                mode_reg[k]  <= spht_pkg::MODE_NONE;
                fill_reg[k]  <= '0;
                hfill_reg[k] <= '0;
                base_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            coll_reg      <= coll_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            used_reg      <= used_next;
            mode_reg      <= mode_next;
            fill_reg      <= fill_next;
            hfill_reg     <= hfill_next;
            base_reg      <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req.valid)
        begin
            rtype_reg <= spht_pkg::req_t'(req.req_type);
            sess_reg  <= req.session;
            saddr_reg <= req.code_address;
            idx_reg   <= req.entry_index;
        end
        i_reg   <= i_next;
        n_reg   <= n_next;
        j_reg   <= j_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (samp_we)
        begin
            samp_mem[samp_wa] <= saddr_reg;
        end
        if (samp_re)
        begin
            samp_rd_reg <= samp_mem[samp_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ha_we)
        begin
            haddr_mem[h_wa] <= samp_rd_reg;
        end
        if (hh_we)
        begin
            hhits_mem[h_wa] <= hh_wd;
        end
        if (h_re)
        begin
            haddr_rd_reg <= haddr_mem[h_ra];
            hhits_rd_reg <= hhits_mem[h_ra];
        end
    end

    assign req.ready           = (state_reg == ST_IDLE);
    assign res.valid           = out_valid_reg;
    assign res.ok              = out_reg.ok;
    assign res.new_session     = out_reg.new_session;
    assign res.count_out       = out_reg.count_out;
    assign res.address_out     = out_reg.address_out;
    assign res.percent_q8      = out_reg.percent_q8;
    assign res.session_count   = out_reg.session_count;
    assign res.total_collected = out_reg.total_collected;
    assign res.total_dropped   = out_reg.total_dropped;

`ifndef SYNTH
    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(active_reg) <= SESSIONS) else $error("active session count overflow");
    a_distinct_le_walked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_AN_SLAT || state_reg == ST_AN_CMP) |-> n_reg <= i_reg)
        else $error("more distinct entries than samples walked");
    a_search_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_AN_CMP) |-> j_reg < n_reg)
        else $error("compare beyond table fill");
    a_done_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!out_valid_reg || res.ready)) |=> out_valid_reg)
        else $error("result lost at output register");
`endif

endmodule

FILE: tb/sample_profiler_hot_address_table_tb.sv
// Self-checking testbench for sample_profiler_hot_address_table: a directed table and
// random request streams, every result checked against typed rows or an in-bench model.
// Depends on spht_pkg, spht_req_if, spht_res_if and the top level.
`timescale 1ns / 100ps

module sample_profiler_hot_address_table_tb;

    localparam int NSLOT  = spht_pkg::SESSIONS_DEF;
    localparam int NSAMP  = spht_pkg::SAMPLES_DEF;
    localparam int NHOT   = spht_pkg::HOT_DEF;
    localparam int NSTEER = 28;

    typedef struct {
        spht_pkg::req_t kind;
        logic [7:0]     sess;
        logic [63:0]    addr;
        logic [9:0]     idx;
        bit             typed;
        spht_pkg::res_t want;
    } steer_row_t;

    logic clk;
    logic rst_n;

    spht_req_if req_ch();
    spht_res_if res_ch();

    sample_profiler_hot_address_table u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // profiler state as the block should hold it
    bit              slot_busy [NSLOT];
    spht_pkg::mode_t slot_state [NSLOT];
    int unsigned     buf_fill [NSLOT];
    logic [63:0]     buf_addr [NSLOT][NSAMP];
    int unsigned     table_fill [NSLOT];
    int unsigned     table_base [NSLOT];
    logic [63:0]     table_addr [NSLOT][NHOT];
    int unsigned     table_hits [NSLOT][NHOT];
    logic [3:0]      live_sessions;
    logic [31:0]     samples_kept;
    logic [31:0]     samples_lost;

    spht_pkg::res_t  awaited_results [$];
    int              fail_count;
    int              src_idle_pct;
    int              rx_stall_pct;
    bit              hold_request;
    int              hold_left;
    logic [63:0]     addr_pool [8];
    steer_row_t      steer [NSTEER];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic spht_pkg::res_t plain_result(logic ok, logic [3:0] news);
        spht_pkg::res_t r;
        r = '0;
        r.ok = ok;
        r.new_session = news;
        return r;
    endfunction

    function automatic int find_slot(logic [7:0] s);
        if (s == 0 || s > NSLOT)
            return -1;
        if (!slot_busy[s - 1])
            return -1;
        return s - 1;
    endfunction

    task automatic rebuild_table(input int s, output int unsigned n);
        int unsigned j;
        logic [63:0] a;
        n = 0;
        for (int unsigned i = 0; i < buf_fill[s] && n < NHOT; i++)
        begin
            a = buf_addr[s][i];
            for (j = 0; j < n; j++)
                if (table_addr[s][j] == a)
                    break;
            if (j == n)
            begin
                table_addr[s][n] = a;
                table_hits[s][n] = 0;
                n++;
            end
            table_hits[s][j]++;
        end
        table_fill[s] = n;
        table_base[s] = buf_fill[s];
    endtask

    task automatic profile_request(input spht_pkg::req_t k, input logic [7:0] sess,
                                   input logic [63:0] addr, input logic [9:0] idx,
                                   output spht_pkg::res_t r);
        int s;
        int unsigned n;
        longint unsigned h;
        r = '0;
        s = find_slot(sess);
        case (k) inside
            spht_pkg::REQ_START:
            begin
                if (live_sessions < NSLOT)
                begin
                    for (int i = 0; i < NSLOT; i++)
                    begin
                        if (!slot_busy[i])
                        begin
                            slot_busy[i] = 1'b1;
                            slot_state[i] = spht_pkg::MODE_RECORDING;
                            buf_fill[i] = 0;
                            table_fill[i] = 0;
                            table_base[i] = 0;
                            live_sessions = 4'(live_sessions + 1);
                            r.ok = 1'b1;
                            r.new_session = 4'(i + 1);
                            break;
                        end
                    end
                end
            end
            spht_pkg::REQ_STOP:
            begin
                if (s >= 0)
                begin
                    slot_state[s] = spht_pkg::MODE_STOPPED;
                    if (live_sessions > 0)
                        live_sessions = 4'(live_sessions - 1);
                    r.ok = 1'b1;
                end
            end
            spht_pkg::REQ_PAUSE, spht_pkg::REQ_RESUME:
            begin
                if (s >= 0)
                begin
                    slot_state[s] = (k == spht_pkg::REQ_PAUSE) ? spht_pkg::MODE_PAUSED :
                                                                 spht_pkg::MODE_RECORDING;
                    r.ok = 1'b1;
                end
            end
            spht_pkg::REQ_RECORD:
            begin
                if (s >= 0 && slot_state[s] == spht_pkg::MODE_RECORDING)
                begin
                    if (buf_fill[s] >= NSAMP)
                        samples_lost = samples_lost + 32'd1;
                    else
                    begin
                        buf_addr[s][buf_fill[s]] = addr;
                        buf_fill[s]++;
                        samples_kept = samples_kept + 32'd1;
                        r.ok = 1'b1;
                    end
                end
            end
            spht_pkg::REQ_ANALYZE:
            begin
                if (s >= 0)
                begin
                    rebuild_table(s, n);
                    r.count_out = spht_pkg::CNT_W'(n);
                    r.ok = 1'b1;
                end
            end
            spht_pkg::REQ_READ:
            begin
                if (s >= 0 && idx < table_fill[s])
                begin
                    h = table_hits[s][idx];
                    r.ok = 1'b1;
                    r.count_out = spht_pkg::CNT_W'(h);
                    r.address_out = table_addr[s][idx];
                    if (table_base[s] != 0)
                        r.percent_q8 = spht_pkg::PCT_W'((h * spht_pkg::PCT_SCALE) /
                                                        table_base[s]);
                end
            end
            default:
            begin
                r.ok = 1'b1;
                r.session_count = live_sessions;
                r.total_collected = samples_kept;
                r.total_dropped = samples_lost;
            end
        endcase
    endtask

    // Offer one request; valid stays high on return, so only source idles make it dip.
    task automatic send_request(input spht_pkg::req_t k, input logic [7:0] sess,
                                input logic [63:0] addr, input logic [9:0] idx,
                                input bit typed, input spht_pkg::res_t want);
        spht_pkg::res_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= k;
        req_ch.session      <= sess;
        req_ch.code_address <= addr;
        req_ch.entry_index  <= idx;
        do
            @(posedge clk);
        while (!req_ch.ready);
        profile_request(k, sess, addr, idx, r);
        awaited_results.push_back(typed ? want : r);
    endtask

    task automatic send_random_request();
        int pick;
        spht_pkg::req_t k;
        logic [7:0] sess;
        logic [63:0] addr;
        logic [9:0] idx;
        int s;
        pick = $urandom_range(99);
        if (pick < 45)
            k = spht_pkg::REQ_RECORD;
        else if (pick < 53)
            k = spht_pkg::REQ_ANALYZE;
        else if (pick < 73)
            k = spht_pkg::REQ_READ;
        else if (pick < 80)
            k = spht_pkg::REQ_TOTALS;
        else if (pick < 85)
            k = spht_pkg::REQ_START;
        else if (pick < 90)
            k = spht_pkg::REQ_STOP;
        else if (pick < 95)
            k = spht_pkg::REQ_PAUSE;
        else
            k = spht_pkg::REQ_RESUME;
        sess = ($urandom_range(99) < 85) ? 8'($urandom_range(NSLOT, 1)) : 8'($urandom);
        addr = ($urandom_range(99) < 75) ? addr_pool[$urandom_range(7)] : {$urandom, $urandom};
        s = find_slot(sess);
        if (s >= 0 && $urandom_range(99) < 70)
            idx = 10'($urandom_range(table_fill[s]));
        else
            idx = 10'($urandom);
        send_request(k, sess, addr, idx, 1'b0, '0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_request)
            begin
                hold_left = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        spht_pkg::res_t w;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result transaction with nothing outstanding");
                fail_count++;
            end
            else
            begin
                w = awaited_results.pop_front();
                if (res_ch.ok !== w.ok)
                begin
                    $error("ok expected %0d got %0d", w.ok, res_ch.ok);
                    fail_count++;
                end
                if (res_ch.new_session !== w.new_session)
                begin
                    $error("new_session expected %0d got %0d", w.new_session,
                           res_ch.new_session);
                    fail_count++;
                end
                if (res_ch.count_out !== w.count_out)
                begin
                    $error("count_out expected %0d got %0d", w.count_out, res_ch.count_out);
                    fail_count++;
                end
                if (res_ch.address_out !== w.address_out)
                begin
                    $error("address_out expected %h got %h", w.address_out, res_ch.address_out);
                    fail_count++;
                end
                if (res_ch.percent_q8 !== w.percent_q8)
                begin
                    $error("percent_q8 expected %0d got %0d", w.percent_q8, res_ch.percent_q8);
                    fail_count++;
                end
                if (res_ch.session_count !== w.session_count)
                begin
                    $error("session_count expected %0d got %0d", w.session_count,
                           res_ch.session_count);
                    fail_count++;
                end
                if (res_ch.total_collected !== w.total_collected)
                begin
                    $error("total_collected expected %0d got %0d", w.total_collected,
                           res_ch.total_collected);
                    fail_count++;
                end
                if (res_ch.total_dropped !== w.total_dropped)
                begin
                    $error("total_dropped expected %0d got %0d", w.total_dropped,
                           res_ch.total_dropped);
                    fail_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        spht_pkg::res_t totals_reset;
        fail_count = 0;
        src_idle_pct = 0;
        rx_stall_pct = 0;
        hold_request = 1'b0;
        live_sessions = '0;
        samples_kept = '0;
        samples_lost = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            slot_busy[i] = 1'b0;
            slot_state[i] = spht_pkg::MODE_NONE;
            buf_fill[i] = 0;
            table_fill[i] = 0;
            table_base[i] = 0;
        end
        addr_pool = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h1,
                      64'h0000_7FFF_DEAD_BEEF, 64'hFFFF_FFFF_8100_0040, 64'h5555_AAAA_5555_AAAA,
                      64'hAAAA_5555_AAAA_5555};
        totals_reset = plain_result(1'b1, 4'd0);

        // kind, session, address, entry, typed, expected
        steer[0]  = '{spht_pkg::REQ_TOTALS,  8'd0,   64'h0, 10'd0,    1'b1, totals_reset};
        steer[1]  = '{spht_pkg::REQ_STOP,    8'd1,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b0, 4'd0)};
        steer[2]  = '{spht_pkg::REQ_RECORD,  8'd1,   64'h5, 10'd0,    1'b1,
                      plain_result(1'b0, 4'd0)};
        steer[3]  = '{spht_pkg::REQ_START,   8'd0,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b1, 4'd1)};
        steer[4]  = '{spht_pkg::REQ_RECORD,  8'd1,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b1, 4'd0)};
        steer[5]  = '{spht_pkg::REQ_RECORD,  8'd1,   '1,    10'd0,    1'b1,
                      plain_result(1'b1, 4'd0)};
        steer[6]  = '{spht_pkg::REQ_RECORD,  8'd1,   '1,    10'd0,    1'b1,
                      plain_result(1'b1, 4'd0)};
        steer[7]  = '{spht_pkg::REQ_PAUSE,   8'd1,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b1, 4'd0)};
        steer[8]  = '{spht_pkg::REQ_RECORD,  8'd1,   64'h7, 10'd0,    1'b1,
                      plain_result(1'b0, 4'd0)};
        steer[9]  = '{spht_pkg::REQ_RESUME,  8'd1,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b1, 4'd0)};
        steer[10] = '{spht_pkg::REQ_ANALYZE, 8'd1,   64'h0, 10'd0,    1'b0, '0};
        steer[11] = '{spht_pkg::REQ_READ,    8'd1,   64'h0, 10'd0,    1'b0, '0};
        steer[12] = '{spht_pkg::REQ_READ,    8'd1,   64'h0, 10'd1,    1'b0, '0};
        steer[13] = '{spht_pkg::REQ_READ,    8'd1,   64'h0, 10'd2,    1'b1,
                      plain_result(1'b0, 4'd0)};
        steer[14] = '{spht_pkg::REQ_READ,    8'd0,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b0, 4'd0)};
        steer[15] = '{spht_pkg::REQ_READ,    8'd255, '1,    10'd1023, 1'b1,
                      plain_result(1'b0, 4'd0)};
        steer[16] = '{spht_pkg::REQ_START,   8'd0,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b1, 4'd2)};
        steer[17] = '{spht_pkg::REQ_START,   8'd0,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b1, 4'd3)};
        steer[18] = '{spht_pkg::REQ_START,   8'd0,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b1, 4'd4)};
        steer[19] = '{spht_pkg::REQ_START,   8'd0,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b0, 4'd0)};
        steer[20] = '{spht_pkg::REQ_STOP,    8'd2,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b1, 4'd0)};
        steer[21] = '{spht_pkg::REQ_STOP,    8'd2,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b1, 4'd0)};
        // stopped slots stay in use, so no slot is free
        steer[22] = '{spht_pkg::REQ_START,   8'd0,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b0, 4'd0)};
        steer[23] = '{spht_pkg::REQ_RESUME,  8'd2,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b1, 4'd0)};
        steer[24] = '{spht_pkg::REQ_RECORD,  8'd5,   64'h9, 10'd0,    1'b1,
                      plain_result(1'b0, 4'd0)};
        steer[25] = '{spht_pkg::REQ_ANALYZE, 8'd3,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b1, 4'd0)};
        steer[26] = '{spht_pkg::REQ_READ,    8'd3,   64'h0, 10'd0,    1'b1,
                      plain_result(1'b0, 4'd0)};
        steer[27] = '{spht_pkg::REQ_TOTALS,  8'd9,   64'h0, 10'd0,    1'b0, '0};

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = spht_pkg::REQ_TOTALS;
        req_ch.session = '0;
        req_ch.code_address = '0;
        req_ch.entry_index = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steer[i])
            send_request(steer[i].kind, steer[i].sess, steer[i].addr, steer[i].idx,
                         steer[i].typed, steer[i].want);

        for (int phase = 0; phase < 4; phase++)
        begin
            src_idle_pct = (phase == 1) ? 58 : (phase == 3) ? 12 : 0;
            rx_stall_pct = (phase == 2) ? 58 : (phase == 3) ? 12 : 0;
            repeat (140)
                send_random_request();
        end

        // long receiver hold while records keep coming: the block must back up
        src_idle_pct = 0;
        rx_stall_pct = 0;
        @(posedge clk);
        hold_request = 1'b1;
        repeat (20)
            send_request(spht_pkg::REQ_RECORD, 8'd1, addr_pool[$urandom_range(7)], 10'd0,
                         1'b0, '0);
        send_request(spht_pkg::REQ_TOTALS, 8'd0, 64'h0, 10'd0, 1'b0, '0);

        // resume slot 1, add a few samples, analyze and read back its first entries
        send_request(spht_pkg::REQ_RESUME, 8'd1, 64'h0, 10'd0, 1'b0, '0);
        repeat (4)
            send_request(spht_pkg::REQ_RECORD, 8'd1, addr_pool[$urandom_range(7)], 10'd0,
                         1'b0, '0);
        send_request(spht_pkg::REQ_ANALYZE, 8'd1, 64'h0, 10'd0, 1'b0, '0);
        for (int i = 0; i < 6; i++)
            send_request(spht_pkg::REQ_READ, 8'd1, 64'h0, 10'(i), 1'b0, '0);
        send_request(spht_pkg::REQ_TOTALS, 8'd0, 64'h0, 10'd0, 1'b0, '0);
        req_ch.valid <= 1'b0;

        wait_drained();
        repeat (60) @(posedge clk);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
